@@ rtl/mfe_pkg.sv @@
package mfe_pkg;

  localparam int FILTER_COUNT   = 32;
  localparam int FFT_SIZE       = 512;
  localparam int SAMPLE_RATE_HZ = 16000;
  localparam int LOW_FREQ_HZ    = 20;
  localparam int MEL_BREAK_HZ   = 700;

  localparam int HALF_BINS = FFT_SIZE / 2;
  localparam int BIN_IDX_W = $clog2(HALF_BINS);
  localparam int BIN_POS_W = $clog2(HALF_BINS + 1);
  localparam int SUM_AW    = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int STEPS     = FILTER_COUNT + 1;

  localparam int POWER_W  = 32;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 48;
  localparam int FILT_W   = 6;
  localparam int ONE_Q15  = 32768;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                rise_ok;
    logic [FILT_W-1:0]   rise_f;
    logic [WEIGHT_W-1:0] rise_w;
    logic                fall_ok;
    logic [FILT_W-1:0]   fall_f;
    logic [WEIGHT_W-1:0] fall_w;
  } rom_entry_t;

  typedef rom_entry_t [HALF_BINS-1:0] rom_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RISE_MUL,
    S_RISE_ADD,
    S_FALL_MUL,
    S_FALL_ADD,
    S_EMIT_RD,
    S_EMIT_LOAD
  } state_t;

  // Unsigned Q.32 log2 by repeated squaring; elaboration only.
  function automatic logic [63:0] log2_q32(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    int          e;
    logic        found;
    e     = 0;
    found = 1'b0;
    r     = '0;
    if (x != '0) begin
      for (int b = 63; b >= 0; b--) begin
        if (!found && x[b]) begin
          e     = b;
          found = 1'b1;
        end
      end
      if (e >= 31) m = x >> (e - 31);
      else         m = x << (31 - e);
      r = 64'(e) << 32;
      for (int b = 31; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m    = m >> 1;
          r[b] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  localparam logic [63:0] G_LOW =
    log2_q32(64'(MEL_BREAK_HZ + LOW_FREQ_HZ) * 64'(FFT_SIZE));
  localparam logic [63:0] G_HIGH =
    log2_q32(64'(MEL_BREAK_HZ) * 64'(FFT_SIZE) +
             (64'(SAMPLE_RATE_HZ) * 64'(FFT_SIZE)) / 2);
  localparam logic        DEGENERATE = (G_HIGH <= G_LOW);
  localparam logic [63:0] G_SPAN     = DEGENERATE ? 64'd1 : (G_HIGH - G_LOW);

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] g;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] r;
    rom = '0;
    if (!DEGENERATE) begin
      for (int j = 0; j < HALF_BINS; j++) begin
        g = log2_q32(64'(MEL_BREAK_HZ) * 64'(FFT_SIZE) + 64'(j) * 64'(SAMPLE_RATE_HZ));
        if (g > G_LOW) begin
          t = (((g - G_LOW) * 64'(STEPS)) << 16) / G_SPAN;
          if (t != '0) begin
            k = t >> 16;
            r = (t & 64'hFFFF) >> 1;
            if (k < 64'(FILTER_COUNT)) begin
              rom[j].rise_ok = 1'b1;
              rom[j].rise_f  = FILT_W'(k);
              rom[j].rise_w  = WEIGHT_W'(r);
            end
            if (k >= 64'd1 && k <= 64'(FILTER_COUNT)) begin
              rom[j].fall_ok = 1'b1;
              rom[j].fall_f  = FILT_W'(k - 64'd1);
              rom[j].fall_w  = WEIGHT_W'(64'(ONE_Q15) - r);
            end
          end
        end
      end
    end
    return rom;
  endfunction

  localparam rom_t WEIGHT_ROM = build_rom();

endpackage

@@ rtl/mfe_bin_if.sv @@
interface mfe_bin_if import mfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] power;
  logic               frame_end;

  modport source (output valid, power, frame_end, input ready);
  modport sink   (input valid, power, frame_end, output ready);
endinterface

@@ rtl/mfe_energy_if.sv @@
interface mfe_energy_if import mfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  mel_energy;
  logic [FILT_W-1:0] filter_index;
  logic              last_filter;

  modport source (output valid, mel_energy, filter_index, last_filter, input ready);
  modport sink   (input valid, mel_energy, filter_index, last_filter, output ready);
endinterface

@@ rtl/mfe_mac.sv @@
module mfe_mac import mfe_pkg::*; (
  input  logic                clk,
  input  logic                mul_en,
  input  logic [POWER_W-1:0]  a,
  input  logic [WEIGHT_W-1:0] b,
  input  sum_t                acc,
  output sum_t                sum
);

  sum_t           product;
  logic [SUM_W:0] wide;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product <= SUM_W'(a) * SUM_W'(b);
    end
  end

  // saturate at all ones on carry out
  assign wide = {1'b0, acc} + {1'b0, product};
  assign sum  = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];

endmodule

@@ rtl/mfe_sum_store.sv @@
module mfe_sum_store import mfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SUM_AW-1:0] rd_addr,
  output sum_t              rd_data,
  input  logic              wr_en,
  input  logic [SUM_AW-1:0] wr_addr,
  input  sum_t              wr_data,
  input  logic              clr_en,
  input  logic [SUM_AW-1:0] clr_addr
);

  sum_t                    mem [FILTER_COUNT];
  logic [FILTER_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // an entry not written since its last readout reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end else if (clr_en) begin
      valid[clr_addr] <= 1'b0;
    end
  end

endmodule

@@ rtl/mel_filterbank_energy.sv @@
// Triangular mel filterbank energy accumulator.
// bin_in carries one power-spectrum bin per request, in bin order, with
// frame_end on the final bin of a frame. The bin position is counted here;
// bins past FFT_SIZE/2 add nothing. Each bin is weighted from a constant
// triangular weight table and added into at most two filter sums.
// A bin passes through the request cycle, then a multiply and a saturating
// add for the rising filter and again for the falling filter, all through
// one shared multiply-add unit and one port pair of the sum store.
// After a frame_end bin, energy_out delivers FILTER_COUNT results in filter
// order, each by a store read and then an output load, the last one marked
// last_filter. energy_out.valid rises after the frame_end bin's falling
// add, a store read and an output load. bin_in is not ready until the last
// result is loaded into the output register. A stall on energy_out holds
// the output register and the readout; nothing is dropped. Each readout
// clears its filter sum, so a short frame leaves zero for the missing bins.
// Reset empties the sum store and the output register at once and clears
// the bin counter; the block is ready in the first cycle after reset.
module mel_filterbank_energy import mfe_pkg::*; (
  input logic         clk,
  input logic         rst,
  mfe_bin_if.sink     bin_in,
  mfe_energy_if.source energy_out
);

  state_t               state;
  state_t               state_next;
  logic [POWER_W-1:0]   power;
  logic                 frame_last;
  rom_entry_t           entry;
  logic                 bin_ok;
  logic [BIN_POS_W-1:0] bin_position;
  logic [SUM_AW-1:0]    emit_idx;

  logic                 accept;
  logic                 out_free;
  logic                 emit_last;
  logic                 emit_load;

  logic                 mul_en;
  logic [WEIGHT_W-1:0]  mul_b;
  logic                 rd_en;
  logic [SUM_AW-1:0]    rd_addr;
  sum_t                 rd_data;
  logic                 wr_en;
  logic [SUM_AW-1:0]    wr_addr;
  sum_t                 mac_sum;

  logic                 out_valid;
  sum_t                 out_energy;
  logic [FILT_W-1:0]    out_index;
  logic                 out_last;

  assign accept    = bin_in.valid && bin_in.ready;
  assign out_free  = !out_valid || energy_out.ready;
  assign emit_last = (emit_idx == SUM_AW'(FILTER_COUNT - 1));
  assign emit_load = (state == S_EMIT_LOAD) && out_free;

  mfe_mac u_mac (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (power),
    .b      (mul_b),
    .acc    (rd_data),
    .sum    (mac_sum)
  );

  mfe_sum_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (mac_sum),
    .clr_en   (emit_load),
    .clr_addr (emit_idx)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_RISE_MUL;
      S_RISE_MUL:  state_next = S_RISE_ADD;
      S_RISE_ADD:  state_next = S_FALL_MUL;
      S_FALL_MUL:  state_next = S_FALL_ADD;
      S_FALL_ADD:  state_next = frame_last ? S_EMIT_RD : S_IDLE;
      S_EMIT_RD:   state_next = S_EMIT_LOAD;
      S_EMIT_LOAD: begin
        if (out_free) state_next = emit_last ? S_IDLE : S_EMIT_RD;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    bin_in.ready = 1'b0;
    mul_en       = 1'b0;
    mul_b        = entry.rise_w;
    rd_en        = 1'b0;
    rd_addr      = entry.rise_f[SUM_AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = entry.rise_f[SUM_AW-1:0];
    case (state)
      S_IDLE:     bin_in.ready = 1'b1;
      S_RISE_MUL: begin
        mul_en = 1'b1;
        rd_en  = 1'b1;
      end
      S_RISE_ADD: wr_en = bin_ok && entry.rise_ok;
      S_FALL_MUL: begin
        mul_en  = 1'b1;
        mul_b   = entry.fall_w;
        rd_en   = 1'b1;
        rd_addr = entry.fall_f[SUM_AW-1:0];
      end
      S_FALL_ADD: begin
        wr_en   = bin_ok && entry.fall_ok;
        wr_addr = entry.fall_f[SUM_AW-1:0];
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = emit_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      power      <= bin_in.power;
      frame_last <= bin_in.frame_end;
      entry      <= WEIGHT_ROM[bin_position[BIN_IDX_W-1:0]];
      bin_ok     <= (bin_position < BIN_POS_W'(HALF_BINS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position <= '0;
      emit_idx     <= '0;
    end else begin
      if (accept && bin_position < BIN_POS_W'(HALF_BINS)) begin
        bin_position <= bin_position + 1'b1;
      end
      if (emit_load) begin
        if (emit_last) begin
          emit_idx     <= '0;
          bin_position <= '0;
        end else begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (energy_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_energy <= rd_data;
      out_index  <= FILT_W'(emit_idx);
      out_last   <= emit_last;
    end
  end

  assign energy_out.valid        = out_valid;
  assign energy_out.mel_energy   = out_energy;
  assign energy_out.filter_index = out_index;
  assign energy_out.last_filter  = out_last;

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !bin_in.ready)
    else $error("bin_in ready right after a request");

  a_bin_position_range: assert property (@(posedge clk) disable iff (rst)
    bin_position <= BIN_POS_W'(HALF_BINS))
    else $error("bin position past half spectrum");

  a_last_filter_index: assert property (@(posedge clk) disable iff (rst)
    (energy_out.valid && energy_out.last_filter) |->
      energy_out.filter_index == FILT_W'(FILTER_COUNT - 1))
    else $error("last_filter on wrong filter index");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (emit_load && emit_last) |=> (bin_position == '0 && emit_idx == '0))
    else $error("frame counters not cleared after readout");

endmodule
